// ===== sv/aes_ctr_pkg.sv =====
// Package with AES tables, round functions and shared types for the keystream block.
package aes_ctr_pkg;

   localparam int unsigned BlockBytes = 16;
   localparam int unsigned KeyWords   = 8;
   localparam int unsigned CfgIdxW    = 2;
   // AES-256 always runs fourteen rounds.
   localparam int unsigned RoundCount = 14;

   typedef enum logic [1:0] {
      CSR_KEY_WORD_0 = 2'd0,
      CSR_KEY_WORD_1 = 2'd1,
      CSR_KEY_WORD_2 = 2'd2,
      CSR_KEY_WORD_3 = 2'd3
   } csr_index_type;

   // Metadata that travels beside the state through the round chain.
   typedef struct packed {
      logic       valid;
      logic [4:0] want;
   } tag_type;

   typedef logic [7:0] sbox_table_type [256];

   localparam sbox_table_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // Byte j of a 128-bit state where byte 0 sits in bits 127:120.
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int j);
      return s[127 - 8*j -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // SubBytes followed by ShiftRows.
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(r + 4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3, all;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c + 1);
         a2 = get_byte(s, 4*c + 2);
         a3 = get_byte(s, 4*c + 3);
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                                a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
      end
      return t;
   endfunction

endpackage

// ===== sv/aes_ctr_key_sched.sv =====
// Key schedule sequencer: expands the 256-bit key into round keys one word a cycle.
module aes_ctr_key_sched
   import aes_ctr_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [255:0]                   key,
   output logic [128*(RoundCount+1)-1:0]  rkey_bus,
   output logic                           busy
);
   localparam int unsigned SchedWords = 4 * (RoundCount + 1);
   localparam int unsigned IdxW = $clog2(SchedWords + 1);

   // Schedule words, word 0 in the highest bits; fixed-tap shift register.
   logic [31:0]     w_ff [SchedWords];
   logic [31:0]     w_in [SchedWords];
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [7:0]      rc_ff, rc_in;
   logic            run_ff, run_in;
   logic [31:0]     t;
   logic [31:0]     new_w;

   always_comb begin
      t = w_ff[SchedWords-1];
      if (idx_ff[2:0] == 3'd0) begin
         t = sub_word({t[23:0], t[31:24]}) ^ {rc_ff, 24'h0};
      end else if (idx_ff[2:0] == 3'd4) begin
         t = sub_word(t);
      end
      new_w = w_ff[SchedWords-KeyWords] ^ t;
   end

   // Words enter at the bottom and shift up, so after the run word 0 is at the top.
   always_comb begin
      w_in   = w_ff;
      idx_in = idx_ff;
      rc_in  = rc_ff;
      run_in = run_ff;
      if (start) begin
         for (int i = 0; i < SchedWords; i++) w_in[i] = '0;
         for (int i = 0; i < KeyWords; i++) begin
            w_in[SchedWords-KeyWords+i] = key[255 - 32*i -: 32];
         end
         idx_in = IdxW'(KeyWords);
         rc_in  = 8'h01;
         run_in = 1'b1;
      end else if (run_ff) begin
         for (int i = 0; i < SchedWords - 1; i++) w_in[i] = w_ff[i+1];
         w_in[SchedWords-1] = new_w;
         if (idx_ff[2:0] == 3'd0) rc_in = xtime(rc_ff);
         idx_in = idx_ff + 1'b1;
         if (idx_ff == IdxW'(SchedWords - 1)) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         idx_ff <= '0;
         rc_ff  <= 8'h01;
         for (int i = 0; i < SchedWords; i++) w_ff[i] <= '0;
      end else begin
         run_ff <= run_in;
         idx_ff <= idx_in;
         rc_ff  <= rc_in;
         w_ff   <= w_in;
      end
   end

   always_comb begin
      for (int i = 0; i < SchedWords; i++) begin
         rkey_bus[32*(SchedWords-i)-1 -: 32] = w_ff[i];
      end
   end

   assign busy = run_ff | start;

endmodule

// ===== sv/aes_ctr_round_cell.sv =====
// One AES round cell: applies one round to the state it receives and passes it on.
module aes_ctr_round_cell
   import aes_ctr_pkg::*;
#(
   parameter bit IS_LAST = 1'b0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic [127:0]  round_key,
   input  logic [127:0]  state_i,
   input  tag_type       tag_i,
   output logic [127:0]  state_o,
   output tag_type       tag_o
);
   logic [127:0] state_ff, state_in;
   tag_type      tag_ff;
   logic [127:0] ss;

   always_comb begin
      ss = sub_shift(state_i);
      state_in = (IS_LAST ? ss : mix_columns(ss)) ^ round_key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) state_ff <= state_in;
   end

   assign state_o = state_ff;
   assign tag_o   = tag_ff;

endmodule

// ===== sv/aes256_ctr_keystream.sv =====
// Top level of the AES-256 counter-mode keystream generator.
//
//  channel  dir  fields (low bit up)                                   handshake
//  req_     in   tdata: nonce_high, nonce_low, block_counter, bytes_wanted   tvalid/tready
//  rsp_     out  tdata: keystream_high, keystream_low, bytes_valid           tvalid/tready
//  csr_     in   write enable, 2-bit index, 64-bit data                   no wait
//
// Requests pass one input cell that adds round key 0, then a row of RoundCount
// round cells, then the masking output register. One item is taken in every cycle
// while no key schedule runs; the whole cell row advances together and freezes
// while the output register holds an item that is not taken.
// Writing key word 3 runs the key schedule, one schedule word per cycle, so requests
// are held off from the write cycle until the schedule has finished.
// Reset leaves the round keys all zero (not the expansion of a zero key).
module aes256_ctr_keystream
   import aes_ctr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // nonce_high[63:0], nonce_low[95:64], block_counter[127:96], bytes_wanted[132:128]
   input  logic [135:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // keystream_high[63:0], keystream_low[127:64], bytes_valid[132:128]
   output logic [135:0]  rsp_tdata,
   input  logic          csr_wen,
   input  logic [CfgIdxW-1:0] csr_index,
   input  logic [63:0]   csr_wdata
);
   localparam int unsigned NumKeys = RoundCount + 1;

   logic [63:0]  key_ff [4];
   logic [128*NumKeys-1:0] rkey_bus;
   logic         sched_busy;
   logic         start;
   logic         advance;

   logic [127:0] st0_ff;
   tag_type      tag0_ff;
   logic [127:0] st   [NumKeys];
   tag_type      tag  [NumKeys];

   logic [127:0] blk;
   logic [4:0]   want;
   logic         out_valid_ff;
   logic [127:0] out_ks_ff, out_ks_in;
   logic [4:0]   out_cnt_ff;

   assign start = csr_wen && (csr_index == CSR_KEY_WORD_3);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else if (csr_wen) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   // The schedule is fed the new word 3 directly as it is written.
   aes_ctr_key_sched u_sched (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .key        ({key_ff[0], key_ff[1], key_ff[2], csr_wdata}),
      .rkey_bus   (rkey_bus),
      .busy       (sched_busy)
   );

   // The row moves whenever the output register is free or being emptied.
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance && !sched_busy;

   // Counter block: nonce high, nonce low, then counter, all big-endian.
   assign blk  = {req_tdata[63:0], req_tdata[95:64], req_tdata[127:96]};
   assign want = (req_tdata[132:128] > 5'd16) ? 5'd16 : req_tdata[132:128];

   // Input cell: round key 0 whitening.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
      end else if (advance) begin
         tag0_ff <= '{valid: req_tvalid && req_tready, want: want};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) st0_ff <= blk ^ rkey_bus[128*NumKeys-1 -: 128];
   end

   assign st[0]  = st0_ff;
   assign tag[0] = tag0_ff;

   for (genvar r = 1; r < NumKeys; r++) begin : g_round
      aes_ctr_round_cell #(.IS_LAST(r == RoundCount)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .round_key (rkey_bus[128*(NumKeys-r)-1 -: 128]),
         .state_i   (st[r-1]),
         .tag_i     (tag[r-1]),
         .state_o   (st[r]),
         .tag_o     (tag[r])
      );
   end

   // Bytes at or beyond the wanted count are zeroed.
   always_comb begin
      for (int j = 0; j < BlockBytes; j++) begin
         out_ks_in[127 - 8*j -: 8] = (5'(j) < tag[RoundCount].want) ?
                                     st[RoundCount][127 - 8*j -: 8] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= tag[RoundCount].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ks_ff  <= out_ks_in;
         out_cnt_ff <= tag[RoundCount].want;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_cnt_ff, out_ks_ff[63:0], out_ks_ff[127:64]};

   // A request is never taken while the key schedule runs.
   assert property (@(posedge clock) disable iff (reset)
      sched_busy |-> !(req_tvalid && req_tready))
      else $error("request accepted during key expansion");

   // A stalled response keeps its data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   // Valid responses report at most a whole block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[132:128] <= 5'd16))
      else $error("byte count out of range");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the AES-256 counter-mode keystream generator.
module tb;
   import aes_ctr_pkg::*;

   typedef struct packed {
      logic [4:0]  want;
      logic [31:0] counter;
      logic [31:0] nonce_lo;
      logic [63:0] nonce_hi;
   } block_req_type;

   typedef struct packed {
      logic [4:0]  count;
      logic [63:0] ks_lo;
      logic [63:0] ks_hi;
   } keystream_type;

   localparam int ROUNDS     = RoundCount;
   localparam int DRAIN_WAIT = 100;
   localparam int WATCHDOG   = 5000;
   localparam int LONG_HOLD  = 200;

   localparam logic [7:0] SB [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   // nonce_high, nonce_low, block_counter, bytes_wanted (low bit up)
   logic [135:0]  req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   // keystream_high, keystream_low, bytes_valid (low bit up)
   logic [135:0]  rsp_tdata;
   logic          csr_wen;
   logic [CfgIdxW-1:0] csr_index;
   logic [63:0]   csr_wdata;

   aes256_ctr_keystream dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // The predictor keeps its own key words and round keys; 30 entries of 64 bits.
   logic [63:0] key_shadow [4];
   logic [63:0] rk_table [30];

   block_req_type pending_blocks [$];
   keystream_type expected_ks [$];

   int  fail_count;
   int  sent_count;
   int  got_count;
   int  idle_cycles;
   bit  stim_done;
   bit  long_hold_req;
   int  send_gap;
   int  recv_gap;
   int  hold_count;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [7:0] gmul2(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub4(input logic [31:0] w);
      return {SB[w[31:24]], SB[w[23:16]], SB[w[15:8]], SB[w[7:0]]};
   endfunction

   // Standard AES-256 key schedule over the four shadow key words.
   function automatic void expand_round_keys();
      logic [31:0] w [60];
      logic [31:0] t;
      logic [7:0]  rcon;
      rcon = 8'h01;
      for (int i = 0; i < 8; i++) begin
         w[i] = i[0] ? key_shadow[i/2][31:0] : key_shadow[i/2][63:32];
      end
      for (int i = 8; i < 60; i++) begin
         t = w[i-1];
         if (i % 8 == 0) begin
            t = sub4({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
            rcon = gmul2(rcon);
         end else if (i % 8 == 4) begin
            t = sub4(t);
         end
         w[i] = w[i-8] ^ t;
      end
      for (int i = 0; i < 30; i++) begin
         rk_table[i] = {w[2*i], w[2*i+1]};
      end
   endfunction

   // Encrypts one counter block; state byte 0 sits in bits 127:120.
   function automatic keystream_type encrypt_counter_block(input block_req_type b);
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [127:0] blk;
      logic [127:0] rk;
      logic [7:0]   a0, a1, a2, a3, x;
      logic [4:0]   n;
      keystream_type ks;
      blk = {b.nonce_hi, b.nonce_lo, b.counter};
      for (int j = 0; j < 16; j++) s[j] = blk[127-8*j -: 8];
      for (int r = 0; r <= ROUNDS; r++) begin
         if (r > 0) begin
            for (int c = 0; c < 4; c++)
               for (int q = 0; q < 4; q++) t[q+4*c] = SB[s[q+4*((c+q)%4)]];
            s = t;
            if (r < ROUNDS) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                  x = a0 ^ a1 ^ a2 ^ a3;
                  s[4*c]   = a0 ^ x ^ gmul2(a0 ^ a1);
                  s[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
                  s[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
                  s[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
               end
            end
         end
         rk = {rk_table[2*r], rk_table[2*r+1]};
         for (int j = 0; j < 16; j++) s[j] ^= rk[127-8*j -: 8];
      end
      // Requests above 16 bytes saturate; bytes past the count are zeroed.
      n = (b.want > 5'd16) ? 5'd16 : b.want;
      for (int j = 0; j < 16; j++) begin
         if (j >= n) s[j] = 8'h00;
         blk[127-8*j -: 8] = s[j];
      end
      ks.ks_hi = blk[127:64];
      ks.ks_lo = blk[63:0];
      ks.count = n;
      return ks;
   endfunction

   function automatic block_req_type random_block(input bit full_range);
      block_req_type b;
      b.nonce_hi = {$urandom, $urandom};
      b.nonce_lo = $urandom;
      b.counter  = $urandom;
      b.want     = full_range ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
      return b;
   endfunction

   function automatic block_req_type make_block(input logic [63:0] hi, input logic [31:0] lo,
                                                input logic [31:0] ctr, input logic [4:0] n);
      block_req_type b;
      b.nonce_hi = hi; b.nonce_lo = lo; b.counter = ctr; b.want = n;
      return b;
   endfunction

   // Register write; only issued while the block is idle.
   task automatic write_key_word(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen   <= 1'b0;
      key_shadow[idx] = val;
      if (idx == CfgIdxW'(CSR_KEY_WORD_3)) expand_round_keys();
   endtask

   task automatic load_key(input logic [63:0] k0, k1, k2, k3);
      write_key_word(CfgIdxW'(CSR_KEY_WORD_0), k0);
      write_key_word(CfgIdxW'(CSR_KEY_WORD_1), k1);
      write_key_word(CfgIdxW'(CSR_KEY_WORD_2), k2);
      write_key_word(CfgIdxW'(CSR_KEY_WORD_3), k3);
   endtask

   // Waits until the driver queue is empty and every keystream block has come back.
   task automatic wait_drained();
      while (pending_blocks.size() != 0 || req_tvalid || expected_ks.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) begin
         // A few items carry out-of-range byte counts to reach the saturation path.
         pending_blocks.push_back(random_block($urandom_range(0, 9) == 0));
      end
   endtask

   // Driver: holds an item until accepted, then draws a fresh gap before the next.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
      end else if (req_tvalid && !req_tready) begin
         // Still offering the same item.
      end else begin
         if (req_tvalid) begin
            sent_count <= sent_count + 1;
            expected_ks.push_back(encrypt_counter_block(block_req_type'(req_tdata[132:0])));
         end
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_blocks.size() != 0) begin
            req_tdata  <= {3'b000, pending_blocks.pop_front()};
            req_tvalid <= 1'b1;
            send_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor and receiver: compares each accepted item with the oldest expectation.
   always @(posedge clock) begin
      keystream_type got;
      keystream_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap   <= 0;
         hold_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = keystream_type'(rsp_tdata[132:0]);
            got_count <= got_count + 1;
            if (expected_ks.size() == 0) begin
               $display("%0t: unexpected keystream item %h", $time, got);
               fail_count++;
            end else begin
               want = expected_ks.pop_front();
               if (got.ks_hi !== want.ks_hi) begin
                  $display("%0t: keystream_high expected %h actual %h",
                           $time, want.ks_hi, got.ks_hi);
                  fail_count++;
               end
               if (got.ks_lo !== want.ks_lo) begin
                  $display("%0t: keystream_low expected %h actual %h",
                           $time, want.ks_lo, got.ks_lo);
                  fail_count++;
               end
               if (got.count !== want.count) begin
                  $display("%0t: bytes_valid expected %0d actual %0d",
                           $time, want.count, got.count);
                  fail_count++;
               end
            end
         end
         // A long hold fills the round pipeline so the input side must stall.
         if (long_hold_req && hold_count == 0) begin
            hold_count <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (hold_count > 1) begin
            hold_count <= hold_count - 1;
         end else if (hold_count == 1) begin
            hold_count <= 0;
            rsp_tready <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap   <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready)
               recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         end
      end
   end

   // Watchdog on cycles without any accepted item.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         idle_cycles <= 0;
      end else if (!stim_done) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      fail_count    = 0;
      sent_count    = 0;
      got_count     = 0;
      idle_cycles   = 0;
      stim_done     = 1'b0;
      long_hold_req = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_wen       = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      for (int i = 0; i < 4; i++) key_shadow[i] = '0;
      for (int i = 0; i < 30; i++) rk_table[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Before any key load the round keys are all zero, not an expanded zero key.
      pending_blocks.push_back(make_block('0, '0, '0, 5'd16));
      pending_blocks.push_back(make_block('1, '1, '1, 5'd16));
      pending_blocks.push_back(make_block('0, '0, '0, 5'd0));
      wait_drained();

      // An explicit zero key does expand; then the FIPS-197 test key.
      load_key('0, '0, '0, '0);
      pending_blocks.push_back(make_block('0, '0, '0, 5'd16));
      wait_drained();
      load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
               64'h1011121314151617, 64'h18191a1b1c1d1e1f);
      wait_drained();
      pending_blocks.push_back(make_block(64'h0011223344556677, 32'h8899aabb,
                                          32'hccddeeff, 5'd16));
      // Byte count edges: none, one, partial, full, saturating.
      for (int n = 0; n < 32; n += (n < 2 ? 1 : 7))
         pending_blocks.push_back(make_block(64'h0123456789abcdef, 32'hfedcba98,
                                             32'hffffffff, 5'(n)));
      pending_blocks.push_back(make_block('1, '1, 32'hffffffff, 5'd31));
      pending_blocks.push_back(make_block('0, '0, '0, 5'd1));
      wait_drained();

      // Partial key load: words 0 and 2 alone must not change the round keys.
      write_key_word(CfgIdxW'(CSR_KEY_WORD_0), '1);
      write_key_word(CfgIdxW'(CSR_KEY_WORD_2), 64'h5a5a5a5aa5a5a5a5);
      pending_blocks.push_back(make_block(64'h1, 32'h2, 32'h3, 5'd16));
      wait_drained();

      // Random phases under several keys, all-ones among them.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: load_key('1, '1, '1, '1);
            1: load_key({$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom});
            default: load_key({$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom}, {$urandom, $urandom});
         endcase
         queue_random(95);
         if (phase == 2) begin
            // Receiver holds off a long while the sender keeps offering.
            repeat (20) @(posedge clock);
            long_hold_req <= 1'b1;
            @(posedge clock);
            long_hold_req <= 1'b0;
         end
         // Sender pauses until everything is back, then continues.
         wait_drained();
         queue_random(5);
         wait_drained();
      end

      stim_done = 1'b1;
      $display("Covered %0d keystream items: unloaded and loaded keys, partial key writes,",
               got_count);
      $display("byte counts 0 to 31, random stalls on both sides and a long output hold.");
      if (fail_count == 0 && expected_ks.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
